// ===== rtl/mbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// mbfl_pkg
// Types, codes and character tables for the mbox "From " line recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfl_pkg;

  localparam int DATE_POS_W = 5;
  localparam int PREFIX_LEN = 5;
  localparam int PLAIN_LEN  = 24;
  localparam int ZONED_LEN  = 28;
  localparam logic [DATE_POS_W-1:0] DATE_POS_MAX = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_Y = 8'h79;

  typedef enum logic [3:0] {
    PH_PREFIX     = 4'd0,
    PH_GAP_FROM   = 4'd1,
    PH_SENDER     = 4'd2,
    PH_SENDER_Q   = 4'd3,
    PH_GAP_SENDER = 4'd4,
    PH_PROBE      = 4'd5,
    PH_TTY        = 4'd6,
    PH_TTY_Q      = 4'd7,
    PH_GAP_TTY    = 4'd8,
    PH_DATE       = 4'd9,
    PH_REJECT     = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    CL_NONE  = 3'd0,
    CL_LOWER = 3'd1,
    CL_SPACE = 3'd2,
    CL_DIGIT = 3'd3,
    CL_OPT   = 3'd4,
    CL_COLON = 3'd5,
    CL_UPPER = 3'd7
  } cls_t;

  typedef enum logic [1:0] {
    CAUSE_OK        = 2'd0,
    CAUSE_NO_PREFIX = 2'd1,
    CAUSE_NO_DATE   = 2'd2,
    CAUSE_BAD_DATE  = 2'd3
  } cause_t;

  typedef struct packed {
    logic [DATE_POS_W-1:0] pos;
    logic                  plain_ok;
    logic                  zoned_ok;
  } date_t;

  localparam date_t DATE_CLEAR = '{pos: '0, plain_ok: 1'b1, zoned_ok: 1'b1};

  // verdict handed from the scanner to the output buffer
  typedef struct packed {
    logic   valid;
    logic   is_header;
    cause_t cause;
  } res_t;

  function automatic logic [7:0] from_char(input logic [2:0] idx);
    case (idx)
      3'd0:    from_char = 8'h46;
      3'd1:    from_char = 8'h72;
      3'd2:    from_char = 8'h6f;
      3'd3:    from_char = 8'h6d;
      3'd4:    from_char = CH_SPACE;
      default: from_char = 8'h00;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic class_fits(input cls_t cls, input logic [7:0] c);
    logic dig;
    dig = (c >= 8'h30) && (c <= 8'h39);
    case (cls)
      CL_LOWER: class_fits = (c >= 8'h61) && (c <= 8'h7a);
      CL_UPPER: class_fits = (c >= 8'h41) && (c <= 8'h5a);
      CL_SPACE: class_fits = (c == CH_SPACE);
      CL_DIGIT: class_fits = dig;
      CL_OPT:   class_fits = (c == CH_SPACE) || dig;
      CL_COLON: class_fits = (c == CH_COLON);
      default:  class_fits = 1'b0;
    endcase
  endfunction

  // positions past the end of a form give CL_NONE, which fits nothing
  function automatic cls_t plain_cls(input logic [DATE_POS_W-1:0] p);
    case (p) inside
      5'd0, 5'd4:                          plain_cls = CL_UPPER;
      5'd1, 5'd2, 5'd5, 5'd6:              plain_cls = CL_LOWER;
      5'd3, 5'd7, 5'd10, 5'd19:            plain_cls = CL_SPACE;
      5'd8:                                plain_cls = CL_OPT;
      5'd13, 5'd16:                        plain_cls = CL_COLON;
      5'd9, 5'd11, 5'd12, 5'd14, 5'd15,
      5'd17, 5'd18, [5'd20:5'd23]:         plain_cls = CL_DIGIT;
      default:                             plain_cls = CL_NONE;
    endcase
  endfunction

  function automatic cls_t zoned_cls(input logic [DATE_POS_W-1:0] p);
    case (p) inside
      5'd0, 5'd4, [5'd20:5'd22]:           zoned_cls = CL_UPPER;
      5'd1, 5'd2, 5'd5, 5'd6:              zoned_cls = CL_LOWER;
      5'd3, 5'd7, 5'd10, 5'd19, 5'd23:     zoned_cls = CL_SPACE;
      5'd8:                                zoned_cls = CL_OPT;
      5'd13, 5'd16:                        zoned_cls = CL_COLON;
      5'd9, 5'd11, 5'd12, 5'd14, 5'd15,
      5'd17, 5'd18, [5'd24:5'd27]:         zoned_cls = CL_DIGIT;
      default:                             zoned_cls = CL_NONE;
    endcase
  endfunction

  function automatic date_t date_take(input date_t d, input logic [7:0] c);
    date_t r;
    r = d;
    if (!class_fits(plain_cls(d.pos), c)) r.plain_ok = 1'b0;
    if (!class_fits(zoned_cls(d.pos), c)) r.zoned_ok = 1'b0;
    if (d.pos != DATE_POS_MAX) r.pos = d.pos + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbfl_scan.sv =====
// ----------------------------------------------------------------------------
// mbfl_scan
// Per-byte line scanner: phase, prefix, tty probe and date match state,
// with the verdict for the final byte of a line.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfl_scan import mbfl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] line_byte,
  input  wire logic       line_end,
  output res_t            res
);

  phase_t     phase, phase_next;
  logic [2:0] prefix_count, prefix_count_next;
  logic [1:0] tty_count, tty_count_next;
  date_t      date, date_next;

  always_comb begin
    phase_next        = phase;
    prefix_count_next = prefix_count;
    tty_count_next    = tty_count;
    date_next         = date;
    unique case (phase)
      PH_PREFIX: begin
        if ((prefix_count < 3'(PREFIX_LEN)) && (line_byte == from_char(prefix_count))) begin
          prefix_count_next = prefix_count + 3'd1;
          if (prefix_count_next == 3'(PREFIX_LEN)) phase_next = PH_GAP_FROM;
        end else begin
          phase_next = PH_REJECT;
        end
      end
      PH_GAP_FROM: begin
        if (!is_blank(line_byte))
          phase_next = (line_byte == CH_QUOTE) ? PH_SENDER_Q : PH_SENDER;
      end
      PH_SENDER: begin
        if (is_blank(line_byte)) phase_next = PH_GAP_SENDER;
        else if (line_byte == CH_QUOTE) phase_next = PH_SENDER_Q;
      end
      PH_SENDER_Q: begin
        if (line_byte == CH_QUOTE) phase_next = PH_SENDER;
      end
      PH_GAP_SENDER: begin
        if (!is_blank(line_byte)) begin
          date_next = date_take(date, line_byte);
          if (line_byte == CH_LOW_T) begin
            phase_next     = PH_PROBE;
            tty_count_next = 2'd1;
          end else begin
            phase_next = PH_DATE;
          end
        end
      end
      PH_PROBE: begin
        if ((tty_count == 2'd1) && (line_byte == CH_LOW_T)) begin
          date_next      = date_take(date, line_byte);
          tty_count_next = 2'd2;
        end else if ((tty_count == 2'd2) && (line_byte == CH_LOW_Y)) begin
          phase_next = PH_TTY;
          date_next  = DATE_CLEAR;
        end else begin
          date_next  = date_take(date, line_byte);
          phase_next = PH_DATE;
        end
      end
      PH_TTY: begin
        if (is_blank(line_byte)) phase_next = PH_GAP_TTY;
        else if (line_byte == CH_QUOTE) phase_next = PH_TTY_Q;
      end
      PH_TTY_Q: begin
        if (line_byte == CH_QUOTE) phase_next = PH_TTY;
      end
      PH_GAP_TTY: begin
        if (!is_blank(line_byte)) begin
          date_next  = date_take(DATE_CLEAR, line_byte);
          phase_next = PH_DATE;
        end
      end
      PH_DATE: begin
        date_next = date_take(date, line_byte);
      end
      default: begin
        phase_next = PH_REJECT;
      end
    endcase
  end

  // verdict from the state after this byte
  always_comb begin
    cause_t cause;
    unique case (phase_next)
      PH_PREFIX, PH_REJECT: cause = CAUSE_NO_PREFIX;
      PH_PROBE, PH_DATE: begin
        if ((date_next.plain_ok && (date_next.pos == DATE_POS_W'(PLAIN_LEN))) ||
            (date_next.zoned_ok && (date_next.pos == DATE_POS_W'(ZONED_LEN))))
          cause = CAUSE_OK;
        else
          cause = CAUSE_BAD_DATE;
      end
      default: cause = CAUSE_NO_DATE;
    endcase
    res.valid     = take && line_end;
    res.is_header = (cause == CAUSE_OK);
    res.cause     = cause;
  end

  // the final byte of a line puts everything back to the start state
  always_ff @(posedge clk) begin
    if (rst || (take && line_end)) begin
      phase        <= PH_PREFIX;
      prefix_count <= '0;
      tty_count    <= '0;
      date         <= DATE_CLEAR;
    end else if (take) begin
      phase        <= phase_next;
      prefix_count <= prefix_count_next;
      tty_count    <= tty_count_next;
      date         <= date_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbox_from_line_recognizer.sv =====
// ----------------------------------------------------------------------------
// mbox_from_line_recognizer
// Checks text lines, one byte per item, for the mbox "From " separator form
// and gives one verdict item for each byte marked as the end of a line.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_stall  line_byte[7:0], line_end
//   out      out_valid/ out_stall is_header, reject_cause[1:0]
//
// one input item per cycle while in_stall is low; the scanner state updates in the accepting cycle
// and a verdict is registered in the output register, or parked in the skid entry while out_stall holds it
// a two-entry buffer (output register plus skid) sits on the result side;
// in_stall rises only while the skid entry is occupied
// rst is synchronous and returns the scanner to the start of a line
// ----------------------------------------------------------------------------
`default_nettype none

module mbox_from_line_recognizer import mbfl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] line_byte,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_header,
  output logic [1:0]      reject_cause
);

  logic   take;
  res_t   res;
  logic   skid_valid;
  logic   skid_header;
  cause_t skid_cause;
  logic   slot_free;

  assign in_stall  = skid_valid;
  assign take      = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  mbfl_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .line_byte (line_byte),
    .line_end  (line_end),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (slot_free) begin
        out_valid    <= 1'b1;
        is_header    <= skid_header;
        reject_cause <= skid_cause;
        skid_valid   <= 1'b0;
      end
    end else if (slot_free) begin
      out_valid <= res.valid;
      if (res.valid) begin
        is_header    <= res.is_header;
        reject_cause <= res.cause;
      end
    end else if (res.valid) begin
      // output held by the consumer: park the verdict
      skid_valid  <= 1'b1;
      skid_header <= res.is_header;
      skid_cause  <= res.cause;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !$past(skid_valid)) |-> $past(out_valid && out_stall && take && line_end))
    else $error("skid filled without a stalled output and a new verdict");

  a_header_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_header == (reject_cause == CAUSE_OK)))
    else $error("is_header disagrees with reject_cause");

  a_verdict_next: assert property (@(posedge clk) disable iff (rst)
    (take && line_end && slot_free) |=> out_valid)
    else $error("verdict lost after end of line");

endmodule

`default_nettype wire

// ===== tb/mbox_from_line_recognizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbox_from_line_recognizer_tb
// Feeds text lines byte by byte into the "From " line recognizer and checks
// every verdict against a line-scanning predictor kept in a scoreboard.
// Directed lines hit the prefix, sender, tty and date corners, then random
// well-formed, damaged and noise lines run under several idle/stall mixes.
// ----------------------------------------------------------------------------

module mbox_from_line_recognizer_tb;
  import mbfl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // predicts the verdict of each line and checks the block's verdicts in order
  class verdict_board;
    typedef struct {
      logic   hdr;
      cause_t cause;
    } verdict_t;

    verdict_t    due[$];
    phase_t      scan;
    int unsigned prefix_cnt;
    int unsigned tty_cnt;
    int unsigned date_pos;
    bit          plain_ok;
    bit          zoned_ok;
    int unsigned mismatches;
    int unsigned verdicts_seen;
    int unsigned headers_seen;
    string       from_text  = "From ";
    string       plain_tmpl = "ULLSULLSODSDDCDDCDDSDDDD";
    string       zoned_tmpl = "ULLSULLSODSDDCDDCDDSUUUSDDDD";

    function new();
      restart_line();
    endfunction

    function void restart_date();
      date_pos = 0;
      plain_ok = 1'b1;
      zoned_ok = 1'b1;
    endfunction

    function void restart_line();
      scan       = PH_PREFIX;
      prefix_cnt = 0;
      tty_cnt    = 0;
      restart_date();
    endfunction

    function cls_t slot_class(string tmpl, int unsigned p);
      if (p >= tmpl.len()) return CL_NONE;
      case (tmpl[p])
        "U":     return CL_UPPER;
        "L":     return CL_LOWER;
        "S":     return CL_SPACE;
        "D":     return CL_DIGIT;
        "O":     return CL_OPT;
        "C":     return CL_COLON;
        default: return CL_NONE;
      endcase
    endfunction

    function bit char_fits(cls_t k, logic [7:0] c);
      bit dig;
      dig = (c >= "0") && (c <= "9");
      case (k)
        CL_LOWER: return (c >= "a") && (c <= "z");
        CL_UPPER: return (c >= "A") && (c <= "Z");
        CL_SPACE: return c == CH_SPACE;
        CL_DIGIT: return dig;
        CL_OPT:   return (c == CH_SPACE) || dig;
        CL_COLON: return c == CH_COLON;
        default:  return 1'b0;
      endcase
    endfunction

    function void date_char(logic [7:0] c);
      if (!char_fits(slot_class(plain_tmpl, date_pos), c)) plain_ok = 1'b0;
      if (!char_fits(slot_class(zoned_tmpl, date_pos), c)) zoned_ok = 1'b0;
      if (date_pos < 31) date_pos++;
    endfunction

    function bit blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function void third_word(logic [7:0] c);
      date_char(c);
      if (c == CH_LOW_T) begin
        scan    = PH_PROBE;
        tty_cnt = 1;
      end else begin
        scan = PH_DATE;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      verdict_t v;
      cause_t   k;
      case (scan)
        PH_PREFIX: begin
          if (prefix_cnt < 5 && c == from_text[prefix_cnt]) begin
            prefix_cnt++;
            if (prefix_cnt == 5) scan = PH_GAP_FROM;
          end else begin
            scan = PH_REJECT;
          end
        end
        PH_GAP_FROM: begin
          if (!blank(c)) begin
            if (c == CH_QUOTE) scan = PH_SENDER_Q;
            else scan = PH_SENDER;
          end
        end
        PH_SENDER: begin
          if (blank(c)) scan = PH_GAP_SENDER;
          else if (c == CH_QUOTE) scan = PH_SENDER_Q;
        end
        PH_SENDER_Q: begin
          if (c == CH_QUOTE) scan = PH_SENDER;
        end
        PH_GAP_SENDER: begin
          if (!blank(c)) third_word(c);
        end
        PH_PROBE: begin
          if (tty_cnt == 1 && c == CH_LOW_T) begin
            date_char(c);
            tty_cnt = 2;
          end else if (tty_cnt == 2 && c == CH_LOW_Y) begin
            // a real tty word: the date starts over after it
            scan = PH_TTY;
            restart_date();
          end else begin
            date_char(c);
            scan = PH_DATE;
          end
        end
        PH_TTY: begin
          if (blank(c)) scan = PH_GAP_TTY;
          else if (c == CH_QUOTE) scan = PH_TTY_Q;
        end
        PH_TTY_Q: begin
          if (c == CH_QUOTE) scan = PH_TTY;
        end
        PH_GAP_TTY: begin
          if (!blank(c)) begin
            restart_date();
            date_char(c);
            scan = PH_DATE;
          end
        end
        PH_DATE: date_char(c);
        default: scan = PH_REJECT;
      endcase

      if (!last) return;

      case (scan)
        PH_PREFIX, PH_REJECT: k = CAUSE_NO_PREFIX;
        PH_PROBE, PH_DATE: begin
          if ((plain_ok && date_pos == PLAIN_LEN) || (zoned_ok && date_pos == ZONED_LEN))
            k = CAUSE_OK;
          else
            k = CAUSE_BAD_DATE;
        end
        default: k = CAUSE_NO_DATE;
      endcase
      v.hdr   = (k == CAUSE_OK);
      v.cause = k;
      due.push_back(v);
      restart_line();
    endfunction

    function void check_verdict(logic hdr, logic [1:0] cause);
      verdict_t v;
      verdicts_seen++;
      if (due.size() == 0) begin
        if (mismatches < 10)
          $display("verdict %0d with no line pending: is_header=%b reject_cause=%0d",
                   verdicts_seen, hdr, cause);
        mismatches++;
        return;
      end
      v = due.pop_front();
      if (hdr !== v.hdr || cause !== v.cause) begin
        if (mismatches < 10)
          $display("verdict %0d: expected is_header=%b cause=%0d, got is_header=%b cause=%0d",
                   verdicts_seen, v.hdr, v.cause, hdr, cause);
        mismatches++;
      end else if (hdr) begin
        headers_seen++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] line_byte = 8'h20;
  logic       line_end  = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       is_header;
  logic [1:0] reject_cause;

  verdict_board board = new();
  logic [7:0]   line_buf[$];
  int unsigned  idle_pct   = 0;
  int unsigned  stall_pct  = 0;
  int unsigned  hold_req   = 0;
  int unsigned  hold_left  = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  lines_sent = 0;
  int unsigned  cycles     = 0;

  mbox_from_line_recognizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .line_byte    (line_byte),
    .line_end     (line_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_header    (is_header),
    .reject_cause (reject_cause)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts still pending", cycles, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off once requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_byte(line_byte, line_end);
      if (out_valid && !out_stall) board.check_verdict(is_header, reject_cause);
    end
  end

  task automatic send_byte(logic [7:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    line_byte <= c;
    line_end  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    line_buf.delete();
    put_text(s);
    send_line();
  endtask

  function automatic logic [7:0] upper_char();
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] lower_char();
    return 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'("0" + $urandom_range(9));
  endfunction

  // any non-blank, non-quote byte, high half included
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic void put_blanks();
    int unsigned n;
    n = $urandom_range(1, 3);
    repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void put_quoted();
    int unsigned n;
    n = $urandom_range(0, 5);
    line_buf.push_back(CH_QUOTE);
    repeat (n) line_buf.push_back(quoted_char());
    line_buf.push_back(CH_QUOTE);
  endfunction

  function automatic void put_word(int unsigned lo, int unsigned hi);
    int unsigned n;
    n = $urandom_range(lo, hi);
    repeat (n) line_buf.push_back(word_char());
    if ($urandom_range(2) == 0) begin
      put_quoted();
      n = $urandom_range(0, 3);
      repeat (n) line_buf.push_back(word_char());
    end
  endfunction

  function automatic void put_date(bit zoned);
    line_buf.push_back(upper_char());
    line_buf.push_back(lower_char());
    line_buf.push_back(lower_char());
    line_buf.push_back(CH_SPACE);
    line_buf.push_back(upper_char());
    line_buf.push_back(lower_char());
    line_buf.push_back(lower_char());
    line_buf.push_back(CH_SPACE);
    line_buf.push_back($urandom_range(1) ? CH_SPACE : digit_char());
    line_buf.push_back(digit_char());
    for (int i = 0; i < 3; i++) begin
      line_buf.push_back(i == 0 ? CH_SPACE : CH_COLON);
      line_buf.push_back(digit_char());
      line_buf.push_back(digit_char());
    end
    line_buf.push_back(CH_SPACE);
    if (zoned) begin
      repeat (3) line_buf.push_back(upper_char());
      line_buf.push_back(CH_SPACE);
    end
    repeat (4) line_buf.push_back(digit_char());
  endfunction

  function automatic void build_good_line();
    int unsigned r;
    line_buf.delete();
    put_text("From ");
    if ($urandom_range(3) == 0) put_blanks();
    if ($urandom_range(4) == 0) put_quoted();
    put_word(1, 8);
    put_blanks();
    r = $urandom_range(5);
    if (r < 2) begin
      put_text("tty");
      put_word(0, 3);
      put_blanks();
    end else if (r == 2) begin
      // short tty probe glued to the date
      put_text($urandom_range(1) ? "t" : "tt");
    end
    put_date($urandom_range(1));
  endfunction

  function automatic void spoil_line();
    int unsigned pos;
    int unsigned n;
    case ($urandom_range(3))
      0: begin
        pos = $urandom_range(line_buf.size() - 1);
        line_buf[pos] = 8'($urandom_range(1, 255));
      end
      1: begin
        n = $urandom_range(1, line_buf.size());
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
      2: begin
        n = $urandom_range(1, 6);
        repeat (n) line_buf.push_back(word_char());
      end
      default: begin
        pos = line_buf.size() - 1 - $urandom_range(23);
        line_buf[pos] = 8'($urandom_range(32, 126));
      end
    endcase
  endfunction

  function automatic void build_noise_line();
    int unsigned n;
    string head;
    line_buf.delete();
    head = "From ";
    if ($urandom_range(2) == 0) put_text(head.substr(0, $urandom_range(4)));
    n = $urandom_range(1, 45);
    repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
  endfunction

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n_bytes);
    int unsigned start_bytes;
    int unsigned start_lines;
    int unsigned r;
    idle_pct    = idle;
    stall_pct   = stall;
    start_bytes = bytes_sent;
    start_lines = lines_sent;
    while (bytes_sent - start_bytes < n_bytes || lines_sent - start_lines < 12) begin
      r = $urandom_range(9);
      if (r < 8) begin
        build_good_line();
        if (r >= 5) spoil_line();
      end else begin
        build_noise_line();
      end
      send_line();
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed lines
    send_text("From user Tue Jan  1 00:00:00 2000");
    send_text("From a@b.c Sat Dec 31 23:59:59 9999");
    send_text("From user Mon Feb 11 12:34:56 PST 2001");
    send_text("From  \t user\ttty3 Wed Feb  2 01:02:03 2002");
    send_text("From \"a b\" Thu Mar 10 10:10:10 2010");
    send_text("From x\"q \"y tty\"p q\" Zzz Zzz 99 99:99:99 ZZZ 0000");
    send_text("Fro");
    send_text("F");
    send_text("From\tuser Tue Jan  1 00:00:00 2000");
    send_text("From user");
    send_text("From ");
    send_text("From \"never closed Tue Jan  1 00:00:00 2000");
    send_text("From u tty");
    send_text("From u tt");
    send_text("From u ttx Jan  1 00:00:00 2000");
    send_text("From u tue Jan  1 00:00:00 2000");
    send_text("From u Tue Jan  1 00:00:00 2000 and a long tail past the counter");
    line_buf.delete();
    put_text("From ");
    line_buf.push_back(8'hff);
    line_buf.push_back(8'h80);
    put_text(" Fri Jul  4 07:07:07 1776");
    send_line();
    // a zero byte inside the year
    line_buf.delete();
    put_text("From u Fri Jul  4 07:07:07 17");
    line_buf.push_back(8'h00);
    line_buf.push_back("6");
    send_line();
    drain();

    // fill the output buffer while the receiver holds off
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 150;
    for (int i = 0; i < 12; i++) send_text(i % 2 ? "X" : "F");
    drain();

    run_phase(0, 0, 300);
    run_phase(69, 0, 300);
    run_phase(0, 69, 300);
    run_phase(20, 20, 300);

    $display("sent %0d lines in %0d bytes over no-idle, sender-idle, receiver-stall and mixed runs",
             lines_sent, bytes_sent);
    $display("checked %0d verdicts (%0d headers), %0d mismatches, %0d left pending",
             board.verdicts_seen, board.headers_seen, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
